// ----- hw/rtl/rsc_pkg.sv -----
// Shared types, control word format and constants for the retractable socket controller.
package rsc_pkg;

	typedef struct packed {
		logic        opcode;
		logic        button_pressed;
		logic        at_extended;
		logic        at_retracted;
		logic        plug_sense_a;
		logic        plug_sense_b;
		logic [11:0] pot_sample;
	} item_t;

	typedef struct packed {
		logic [1:0]  motor_command;
		logic [15:0] step_rate;
		logic [1:0]  phase;
		logic [15:0] check_time;
	} result_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] data;
	} cfg_write_t;

	// Register indexes on the configuration channel
	localparam logic [1:0] REG_LOCKOUT_POLLS  = 2'd0;
	localparam logic [1:0] REG_POLL_STEP_MS   = 2'd1;
	localparam logic [1:0] REG_MAX_SPEED      = 2'd2;
	localparam logic [1:0] REG_STEPS_TO_CHECK = 2'd3;

	localparam logic [1:0] MODE_IDLE        = 2'd0;
	localparam logic [1:0] MODE_RETRACT     = 2'd1;
	localparam logic [1:0] MODE_EXT_CHECKED = 2'd2;
	localparam logic [1:0] MODE_EXTEND      = 2'd3;

	localparam logic [1:0] MOTOR_STOP    = 2'd0;
	localparam logic [1:0] MOTOR_RETRACT = 2'd1;
	localparam logic [1:0] MOTOR_EXTEND  = 2'd2;

	localparam logic [7:0]  RST_LOCKOUT_POLLS  = 8'd30;
	localparam logic [9:0]  RST_POLL_STEP_MS   = 10'd200;
	localparam logic [15:0] RST_MAX_SPEED      = 16'd3398;
	localparam logic [15:0] RST_STEPS_TO_CHECK = 16'd9378;
	localparam logic [7:0]  RST_LOCKOUT_COUNT  = 8'd30;
	localparam logic [15:0] RST_MOTOR_SPEED    = 16'd2038;
	localparam logic [15:0] RST_PLUG_CHECK_MS  = 16'd4600;

	localparam logic [9:0]  CHECK_MS_SCALE = 10'd1000;
	localparam logic [15:0] CHECK_MS_NONE  = 16'hFFFF;
	localparam logic [3:0]  DIV_LAST_BIT   = 4'd15;

	// Datapath operations
	localparam logic [3:0] OP_NOP     = 4'd0;
	localparam logic [3:0] OP_POLL    = 4'd1;
	localparam logic [3:0] OP_MUL     = 4'd2;
	localparam logic [3:0] OP_DSTEP   = 4'd4;
	localparam logic [3:0] OP_SET_SPD = 4'd5;
	localparam logic [3:0] OP_LOAD_B  = 4'd6;
	localparam logic [3:0] OP_SET_CHK = 4'd7;
	localparam logic [3:0] OP_EMIT    = 4'd8;

	// Sequencer branch conditions
	localparam logic [2:0] COND_NEXT   = 3'd0;
	localparam logic [2:0] COND_JUMP   = 3'd1;
	localparam logic [2:0] COND_IN     = 3'd2;
	localparam logic [2:0] COND_SAMPLE = 3'd3;
	localparam logic [2:0] COND_CNT    = 3'd4;
	localparam logic [2:0] COND_OUT    = 3'd5;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] cond;
		logic [3:0] target;
	} ctrl_t;

	typedef struct packed {
		logic item_valid;
		logic is_sample;
		logic cnt_nz;
		logic out_free;
	} status_t;

endpackage

// ----- hw/rtl/rsc_useq.sv -----
// Microcode sequencer: control store, step counter and branch logic.
module rsc_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  rsc_pkg::status_t status,
	output rsc_pkg::ctrl_t   ctrl
);
	import rsc_pkg::*;

	localparam logic [3:0] S_WAIT   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_POLL   = 4'd2;
	localparam logic [3:0] S_MUL    = 4'd3;
	localparam logic [3:0] S_SETSPD = 4'd4;
	localparam logic [3:0] S_LOADB  = 4'd5;
	localparam logic [3:0] S_DIVB   = 4'd6;
	localparam logic [3:0] S_SETCHK = 4'd7;
	localparam logic [3:0] S_EMIT   = 4'd8;

	function automatic ctrl_t rom(input logic [3:0] addr);
		ctrl_t w;
		begin
			unique case (addr)
				S_WAIT:   w = '{op: OP_NOP,     cond: COND_IN,     target: S_DISP};
				S_DISP:   w = '{op: OP_NOP,     cond: COND_SAMPLE, target: S_MUL};
				S_POLL:   w = '{op: OP_POLL,    cond: COND_JUMP,   target: S_EMIT};
				S_MUL:    w = '{op: OP_MUL,     cond: COND_NEXT,   target: S_WAIT};
				S_SETSPD: w = '{op: OP_SET_SPD, cond: COND_NEXT,   target: S_WAIT};
				S_LOADB:  w = '{op: OP_LOAD_B,  cond: COND_NEXT,   target: S_WAIT};
				S_DIVB:   w = '{op: OP_DSTEP,   cond: COND_CNT,    target: S_DIVB};
				S_SETCHK: w = '{op: OP_SET_CHK, cond: COND_NEXT,   target: S_WAIT};
				S_EMIT:   w = '{op: OP_EMIT,    cond: COND_OUT,    target: S_WAIT};
				default:  w = '{op: OP_NOP,     cond: COND_JUMP,   target: S_WAIT};
			endcase
			rom = w;
		end
	endfunction

	logic [3:0] upc_q;
	logic [3:0] upc_next;

	assign ctrl = rom(upc_q);

	always_comb begin
		unique case (ctrl.cond)
			COND_NEXT:   upc_next = upc_q + 4'd1;
			COND_JUMP:   upc_next = ctrl.target;
			COND_IN:     upc_next = status.item_valid ? ctrl.target : upc_q;
			COND_SAMPLE: upc_next = status.is_sample ? ctrl.target : upc_q + 4'd1;
			COND_CNT:    upc_next = status.cnt_nz ? ctrl.target : upc_q + 4'd1;
			COND_OUT:    upc_next = status.out_free ? ctrl.target : upc_q;
			default:     upc_next = S_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_WAIT;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

// ----- hw/rtl/retractable_socket_controller_core.sv -----
// Top level of the retractable socket controller: registers, datapath and channels.
//
// Input channel (item_valid/item_ready/item) takes one sensor poll or one speed
// potentiometer sample per transaction; every transaction yields exactly one
// result on the output channel (result_valid/result_ready/result) carrying the
// motor command, step rate, phase and plug check time after that item.
// The configuration channel (cfg_valid/cfg_ready/cfg) is always ready and
// writes one of four registers by index; write it only while the block is idle.
// A poll passes through the dispatch, poll and emit steps. A speed sample's
// result takes one multiply, a reciprocal multiply that divides by the
// full-scale ADC value, a 16-step restoring division of steps to check by
// speed, and a multiply by 1000. The next item is taken only after the
// previous result has been emitted into the output register.
// The microcode sequencer steps through these operations in order.
// The result sits in an output register, so a new item is accepted while the
// previous result waits; a stalled receiver holds the sequencer at its emit
// step once a second result is ready. Reset restores register and state
// defaults and empties the output register.
module retractable_socket_controller_core #(
	parameter int ADC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  rsc_pkg::item_t      item,
	output logic                result_valid,
	input  logic                result_ready,
	output rsc_pkg::result_t    result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  rsc_pkg::cfg_write_t cfg
);
	import rsc_pkg::*;

	localparam int SampleBits = (ADC_BITS < 12) ? ADC_BITS : 12;
	localparam int ProdBits = ADC_BITS + 16;
	localparam logic [15:0] FullScale = 16'((1 << ADC_BITS) - 1);
	localparam int QuotShift = ProdBits + ADC_BITS;
	localparam int RecipBits = ProdBits + 1;
	localparam int QuotBits = ProdBits + RecipBits;
	// Reciprocal of the full-scale value rounded up; exact for every product
	localparam longint unsigned RecipFull =
		((64'd1 << QuotShift) + 64'(FullScale) - 64'd1) / 64'(FullScale);
	localparam logic [RecipBits-1:0] Recip = RecipBits'(RecipFull);

	ctrl_t   ctrl;
	status_t status;

	logic [7:0]  lockout_polls_q;
	logic [9:0]  poll_step_q;
	logic [15:0] max_speed_q;
	logic [15:0] steps_q;

	logic [1:0]  mode_q;
	logic [7:0]  lockout_q;
	logic [15:0] elapsed_q;
	logic [15:0] speed_q;
	logic [15:0] check_q;

	item_t                item_q;
	logic [ProdBits-1:0]  prod_q;
	logic [15:0]          rem_q;
	logic [15:0]          dvd_q;
	logic [15:0]          dvs_q;
	logic [3:0]           cnt_q;
	logic                 out_valid_q;
	result_t              out_q;

	logic                out_free;
	logic                emit;
	logic [16:0]         rem_shift;
	logic                rem_ge;
	logic [16:0]         rem_diff;
	logic [16:0]         elapsed_sum;
	logic [15:0]         elapsed_next;
	logic [25:0]         check_prod;
	logic [QuotBits-1:0] quot_wide;
	logic                plug;

	assign out_free     = !out_valid_q || result_ready;
	assign emit         = (ctrl.op == OP_EMIT) && out_free;
	assign item_ready   = (ctrl.cond == COND_IN);
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign status = '{item_valid: item_valid, is_sample: item_q.opcode,
		cnt_nz: (cnt_q != 4'd0), out_free: out_free};

	rsc_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// One restoring division step: shift in the next dividend bit, try subtract
	assign rem_shift = {rem_q, dvd_q[15]};
	assign rem_ge    = rem_shift >= {1'b0, dvs_q};
	assign rem_diff  = rem_shift - {1'b0, dvs_q};

	assign quot_wide    = QuotBits'(prod_q) * QuotBits'(Recip);
	assign elapsed_sum  = {1'b0, elapsed_q} + 17'(poll_step_q);
	assign elapsed_next = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
	assign check_prod   = 26'(dvd_q) * 26'(CHECK_MS_SCALE);
	assign plug         = item_q.plug_sense_a | item_q.plug_sense_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_polls_q <= RST_LOCKOUT_POLLS;
			poll_step_q     <= RST_POLL_STEP_MS;
			max_speed_q     <= RST_MAX_SPEED;
			steps_q         <= RST_STEPS_TO_CHECK;
		end else if (cfg_valid) begin
			unique case (cfg.index)
				REG_LOCKOUT_POLLS:  lockout_polls_q <= cfg.data[7:0];
				REG_POLL_STEP_MS:   poll_step_q     <= cfg.data[9:0];
				REG_MAX_SPEED:      max_speed_q     <= cfg.data;
				REG_STEPS_TO_CHECK: steps_q         <= cfg.data;
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			lockout_q   <= RST_LOCKOUT_COUNT;
			elapsed_q   <= 16'd0;
			speed_q     <= RST_MOTOR_SPEED;
			check_q     <= RST_PLUG_CHECK_MS;
			cnt_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctrl.op)
				OP_POLL: begin
					unique case (mode_q)
						MODE_IDLE: begin
							if (item_q.button_pressed) begin
								if (lockout_q >= lockout_polls_q) begin
									if (item_q.at_extended) begin
										elapsed_q <= 16'd0;
										mode_q    <= MODE_RETRACT;
									end else begin
										mode_q <= MODE_EXTEND;
									end
								end
								lockout_q <= 8'd1;
							end else if (lockout_q < lockout_polls_q) begin
								lockout_q <= lockout_q + 8'd1;
							end
						end
						MODE_RETRACT: begin
							if (item_q.at_retracted) begin
								mode_q    <= MODE_IDLE;
								lockout_q <= 8'd1;
							end else begin
								elapsed_q <= elapsed_next;
								if (elapsed_next >= check_q && plug) begin
									mode_q <= MODE_EXT_CHECKED;
								end
							end
						end
						default: begin
							if (item_q.at_extended) begin
								mode_q    <= MODE_IDLE;
								lockout_q <= 8'd1;
							end
						end
					endcase
				end
				OP_LOAD_B:  cnt_q   <= DIV_LAST_BIT;
				OP_DSTEP:   cnt_q   <= cnt_q - 4'd1;
				OP_SET_SPD: speed_q <= quot_wide[QuotShift +: 16];
				OP_SET_CHK: check_q <= (speed_q == 16'd0) ? CHECK_MS_NONE : check_prod[15:0];
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		unique case (ctrl.op)
			OP_MUL: begin
				prod_q <= ProdBits'(item_q.pot_sample[SampleBits-1:0]) *
					ProdBits'(max_speed_q);
			end
			OP_LOAD_B: begin
				rem_q <= 16'd0;
				dvd_q <= steps_q;
				dvs_q <= speed_q;
			end
			OP_DSTEP: begin
				rem_q <= rem_ge ? rem_diff[15:0] : rem_shift[15:0];
				dvd_q <= {dvd_q[14:0], rem_ge};
			end
			default: ;
		endcase
		if (emit) begin
			out_q.motor_command <= (mode_q == MODE_IDLE) ? MOTOR_STOP :
				((mode_q == MODE_RETRACT) ? MOTOR_RETRACT : MOTOR_EXTEND);
			out_q.step_rate  <= speed_q;
			out_q.phase      <= mode_q;
			out_q.check_time <= check_q;
		end
	end

endmodule
